// File: hdl/hjd_pkg.sv
// Package for the heartbeat job dispatcher: sizes, request codes, register map,
// the request, response and engine interface structs, and the load clamp.
// Depends on nothing.
package hjd_pkg;

   localparam int NUM_WORKERS = 8;
   localparam int COUNT_BITS  = 16;
   localparam int IDX_BITS    = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
   localparam int STEP_BITS   = $clog2(NUM_WORKERS + 1);
   localparam int CNT_BITS    = $clog2(NUM_WORKERS + 1);

   localparam int OPCODE_BITS = 2;
   localparam int WID_BITS    = 4;
   localparam int LOAD_BITS   = 16;
   localparam int ALIVE_BITS  = 4;

   localparam logic [OPCODE_BITS-1:0] OP_HEARTBEAT = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_JOB       = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_CLEAR     = 2'd2;
   localparam logic [OPCODE_BITS-1:0] OP_RESERVED  = 2'd3;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_STRATEGY = 1'b0;

   localparam logic STRATEGY_ROUND_ROBIN = 1'b0;
   localparam logic STRATEGY_LEAST_CONN  = 1'b1;

   typedef struct packed {
      logic [OPCODE_BITS-1:0] opcode;
      logic [WID_BITS-1:0]    worker_id;
   } req_type;

   typedef struct packed {
      logic [WID_BITS-1:0]   assigned_worker;
      logic                  none_alive;
      logic [LOAD_BITS-1:0]  chosen_load;
      logic [ALIVE_BITS-1:0] alive_count;
   } rsp_type;

   typedef struct packed {
      logic                   start;
      logic [OPCODE_BITS-1:0] opcode;
      logic [WID_BITS-1:0]    worker_id;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } status_type;

   function automatic logic [LOAD_BITS-1:0] clamp_load(input logic [COUNT_BITS-1:0] cnt);
      logic [COUNT_BITS+LOAD_BITS-1:0] wide;
      logic [COUNT_BITS+LOAD_BITS-1:0] limit;
      wide  = (COUNT_BITS+LOAD_BITS)'(cnt);
      limit = (COUNT_BITS+LOAD_BITS)'({LOAD_BITS{1'b1}});
      if (wide > limit) begin
         return {LOAD_BITS{1'b1}};
      end
      return wide[LOAD_BITS-1:0];
   endfunction

endpackage

// File: hdl/hjd_sched.sv
// Scheduling engine: alive marks, per-worker job counts and the round-robin
// pointer, with a sequencer that scans the workers through one comparator.
// Depends on hjd_pkg.
module hjd_sched (
   input  logic                clock,
   input  logic                reset,
   input  logic                strategy,
   input  hjd_pkg::cmd_type    cmd,
   input  logic                out_free,
   output hjd_pkg::status_type status,
   output hjd_pkg::rsp_type    result
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_FINISH
   } state_type;

   state_type                              state_ff;
   logic [hjd_pkg::NUM_WORKERS-1:0]        alive_mask_ff;
   logic [hjd_pkg::CNT_BITS-1:0]           alive_cnt_ff;
   logic [hjd_pkg::COUNT_BITS-1:0]         job_count_ff [hjd_pkg::NUM_WORKERS];
   logic [hjd_pkg::IDX_BITS-1:0]           rr_next_ff;
   logic [hjd_pkg::IDX_BITS-1:0]           scan_idx_ff;
   logic [hjd_pkg::STEP_BITS-1:0]          steps_ff;
   logic                                   lc_ff;
   logic                                   found_ff;
   logic [hjd_pkg::IDX_BITS-1:0]           best_idx_ff;
   logic [hjd_pkg::COUNT_BITS-1:0]         best_cnt_ff;
   logic [hjd_pkg::WID_BITS-1:0]           res_assigned_ff;
   logic                                   res_none_ff;
   logic [hjd_pkg::LOAD_BITS-1:0]          res_load_ff;

   logic                                   hb_valid;
   logic [hjd_pkg::IDX_BITS-1:0]           hb_idx;
   logic [hjd_pkg::IDX_BITS-1:0]           scan_wrap;
   logic [hjd_pkg::IDX_BITS-1:0]           rr_start;
   logic                                   scan_alive;
   logic [hjd_pkg::COUNT_BITS-1:0]         scan_cnt;

   always_comb begin
      hb_valid = (cmd.worker_id != '0)
                 && (hjd_pkg::WID_BITS'(cmd.worker_id) <= hjd_pkg::WID_BITS'(hjd_pkg::NUM_WORKERS));
      hb_idx   = hjd_pkg::IDX_BITS'(cmd.worker_id - hjd_pkg::WID_BITS'(1));
      scan_wrap = (scan_idx_ff == hjd_pkg::IDX_BITS'(hjd_pkg::NUM_WORKERS - 1))
                  ? '0 : scan_idx_ff + hjd_pkg::IDX_BITS'(1);
      rr_start = ({1'b0, rr_next_ff} < (hjd_pkg::IDX_BITS+1)'(hjd_pkg::NUM_WORKERS))
                 ? rr_next_ff : '0;
      scan_alive = alive_mask_ff[scan_idx_ff];
      scan_cnt   = job_count_ff[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         alive_mask_ff <= '0;
         alive_cnt_ff  <= '0;
         rr_next_ff    <= '0;
         for (int i = 0; i < hjd_pkg::NUM_WORKERS; i++) begin
            job_count_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd.start) begin
                  res_assigned_ff <= '0;
                  res_none_ff     <= 1'b0;
                  res_load_ff     <= '0;
                  found_ff        <= 1'b0;
                  steps_ff        <= '0;
                  lc_ff           <= (strategy == hjd_pkg::STRATEGY_LEAST_CONN);
                  state_ff        <= ST_FINISH;
                  case (cmd.opcode)
                     hjd_pkg::OP_HEARTBEAT: begin
                        if (hb_valid && !alive_mask_ff[hb_idx]) begin
                           alive_mask_ff[hb_idx] <= 1'b1;
                           alive_cnt_ff <= alive_cnt_ff + hjd_pkg::CNT_BITS'(1);
                        end
                     end
                     hjd_pkg::OP_CLEAR: begin
                        alive_mask_ff <= '0;
                        alive_cnt_ff  <= '0;
                        rr_next_ff    <= '0;
                        for (int i = 0; i < hjd_pkg::NUM_WORKERS; i++) begin
                           job_count_ff[i] <= '0;
                        end
                     end
                     hjd_pkg::OP_JOB: begin
                        if (alive_cnt_ff == '0) begin
                           res_none_ff <= 1'b1;
                        end else begin
                           scan_idx_ff <= (strategy == hjd_pkg::STRATEGY_LEAST_CONN)
                                          ? '0 : rr_start;
                           state_ff    <= ST_SCAN;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               steps_ff    <= steps_ff + hjd_pkg::STEP_BITS'(1);
               scan_idx_ff <= scan_wrap;
               if (lc_ff) begin
                  if (scan_alive && (!found_ff || (scan_cnt < best_cnt_ff))) begin
                     best_idx_ff <= scan_idx_ff;
                     best_cnt_ff <= scan_cnt;
                     found_ff    <= 1'b1;
                  end
                  if (steps_ff == hjd_pkg::STEP_BITS'(hjd_pkg::NUM_WORKERS - 1)) begin
                     state_ff <= ST_COMMIT;
                  end
               end else if (scan_alive) begin
                  best_idx_ff     <= scan_idx_ff;
                  found_ff        <= 1'b1;
                  rr_next_ff      <= scan_wrap;
                  res_assigned_ff <= hjd_pkg::WID_BITS'(scan_idx_ff) + hjd_pkg::WID_BITS'(1);
                  state_ff        <= ST_FINISH;
               end
            end
            ST_COMMIT: begin
               res_assigned_ff <= hjd_pkg::WID_BITS'(best_idx_ff) + hjd_pkg::WID_BITS'(1);
               res_load_ff     <= hjd_pkg::clamp_load(best_cnt_ff);
               if (best_cnt_ff != {hjd_pkg::COUNT_BITS{1'b1}}) begin
                  job_count_ff[best_idx_ff] <= best_cnt_ff + hjd_pkg::COUNT_BITS'(1);
               end
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      status.busy = (state_ff != ST_IDLE);
      status.done = (state_ff == ST_FINISH) && out_free;
      result.assigned_worker = res_assigned_ff;
      result.none_alive      = res_none_ff;
      result.chosen_load     = res_load_ff;
      result.alive_count     = hjd_pkg::ALIVE_BITS'(alive_cnt_ff);
   end

   // The running alive count must always agree with the alive marks.
   a_alive_count : assert property (@(posedge clock) disable iff (reset)
      alive_cnt_ff == hjd_pkg::CNT_BITS'($countones(alive_mask_ff)))
      else $error("alive count out of step with alive marks");

   // A worker named in a finished result must be alive.
   a_assigned_alive : assert property (@(posedge clock) disable iff (reset)
      (status.done && (res_assigned_ff != '0))
      |-> alive_mask_ff[hjd_pkg::IDX_BITS'(res_assigned_ff - hjd_pkg::WID_BITS'(1))])
      else $error("job given to a worker that is not alive");

   // A job result either names a worker or reports that none is alive, never both.
   a_none_exclusive : assert property (@(posedge clock) disable iff (reset)
      status.done |-> !(res_none_ff && (res_assigned_ff != '0)))
      else $error("result names a worker and flags none alive");

   // A round-robin scan ends within one pass over the workers.
   a_rr_bounded : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && !lc_ff)
      |-> (steps_ff < hjd_pkg::STEP_BITS'(hjd_pkg::NUM_WORKERS)))
      else $error("round-robin scan ran past every worker");

   // The engine only takes a new request when it is idle.
   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (state_ff == ST_IDLE))
      else $error("request started while the engine was busy");

endmodule

// File: hdl/heartbeat_job_dispatcher_core.sv
// Top level of the heartbeat job dispatcher: request and response handshakes,
// the strategy register behind the APB-style port, and the response register.
// Depends on hjd_pkg and hjd_sched.
//
// Requests arrive on req_valid/req_stall/req_payload and each one yields exactly
// one response on rsp_valid/rsp_stall/rsp_payload. A request is taken at a rising
// edge with req_valid high and req_stall low; a response is taken likewise on the
// rsp side. The request opcode selects a heartbeat, a job or a clear.
// Heartbeats, clears and unused opcodes go from idle straight to the finish state.
// A job scans the workers one per cycle through a single comparator: in round robin
// the scan stops at the first alive worker; in least connection all eight counts are
// compared and the chosen count is then updated. One request is in the engine at a
// time. The response register holds a finished response while the receiver stalls,
// and the engine can take the next request meanwhile; it then waits with its own
// result until the register is free. The user must write the strategy register
// through the csr_ port only while no request is in flight; the block itself does
// not enforce it. Reset clears the alive marks, the job counts, the round-robin
// pointer and the strategy, and leaves no response pending.
module heartbeat_job_dispatcher_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  hjd_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output hjd_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [hjd_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [hjd_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [hjd_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   logic                strategy_ff;
   logic                rsp_valid_ff;
   hjd_pkg::rsp_type    rsp_payload_ff;
   hjd_pkg::cmd_type    cmd;
   hjd_pkg::status_type status;
   hjd_pkg::rsp_type    result;
   logic                out_free;
   logic                csr_hit;

   assign csr_hit    = (csr_paddr[hjd_pkg::CSR_ADDR_BITS-1:2] == hjd_pkg::REG_STRATEGY);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? hjd_pkg::CSR_DATA_BITS'(strategy_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff <= hjd_pkg::STRATEGY_ROUND_ROBIN;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         strategy_ff <= csr_pwdata[0];
      end
   end

   assign req_stall     = status.busy;
   assign cmd.start     = req_valid && !req_stall;
   assign cmd.opcode    = req_payload.opcode;
   assign cmd.worker_id = req_payload.worker_id;
   assign out_free      = !rsp_valid_ff || !rsp_stall;

   hjd_sched u_sched (
      .clock    (clock),
      .reset    (reset),
      .strategy (strategy_ff),
      .cmd      (cmd),
      .out_free (out_free),
      .status   (status),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.done) begin
         rsp_valid_ff   <= 1'b1;
         rsp_payload_ff <= result;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
